// ----- design/fir_decimator_assert.svh -----
// assertion macros shared by the fir decimator modules
// expects clk_i and rst_ni in the scope of each use
`ifndef FIR_DECIMATOR_ASSERT_SVH
`define FIR_DECIMATOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define FDEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define FDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fdec_pkg.sv -----
// types and constants shared by the fir decimator modules
// no dependencies
package fdec_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DECIM     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_TAPS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ADDR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_DATA = 2'd3;

  // register field widths
  localparam int DECIM_W = 7;
  localparam int NTAPS_W = 7;
  localparam int ADDR_W  = 6;
  localparam int PHASE_W = 6;
  localparam int COEF_W  = 16;

  localparam logic [DECIM_W-1:0] DECIM_MIN = 7'd1;
  localparam logic [DECIM_W-1:0] DECIM_MAX = 7'd64;
  localparam logic [DECIM_W-1:0] DECIM_RST = 7'd6;
  localparam int                 NTAPS_RST = 20;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH
  } fdec_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic mac_start;
    logic issue;
    logic out_load;
    logic cfg_we;
  } fdec_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic phase_zero;
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } fdec_status_t;

endpackage

// ----- design/fdec_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module fdec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/fdec_ctrl.sv -----
// sequencer of the fir decimator: input/config handshakes and mac run control
// depends on fdec_pkg and fir_decimator_assert.svh
`include "fir_decimator_assert.svh"

module fdec_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  fdec_pkg::fdec_status_t status_i,
  output fdec_pkg::fdec_cmd_t    cmd_o
);
  import fdec_pkg::*;

  fdec_state_e state_q, state_d;
  logic        idle;

  assign idle = (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.phase_zero) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (status_i.last_tap) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status_i.pipe_busy && status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath commands
  // an offered sample goes first, so a register write never meets a sample transfer
  always_comb begin
    in_stall_o      = !idle;
    cfg_ready_o     = idle && !in_valid_i;
    cmd_o           = '0;
    cmd_o.accept    = idle && in_valid_i;
    cmd_o.mac_start = idle && in_valid_i && status_i.phase_zero;
    cmd_o.cfg_we    = idle && cfg_valid_i && !in_valid_i;
    cmd_o.issue     = (state_q == ST_MAC);
    cmd_o.out_load  = (state_q == ST_FLUSH) && !status_i.pipe_busy && status_i.out_free;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // checks
  `FDEC_ASSERT_NEXT(a_mac_entry, cmd_o.mac_start, state_q == ST_MAC, "mac run did not start")
  `FDEC_ASSERT_NOW(a_busy_stalls, status_i.pipe_busy, in_stall_o, "input taken during mac run")
  `FDEC_ASSERT_NOW(a_cfg_quiet, cmd_o.cfg_we, !status_i.pipe_busy, "config write during mac run")
  `FDEC_ASSERT_NEXT(a_load_frees, cmd_o.out_load, !in_stall_o, "input not freed after result")

endmodule

// ----- design/fdec_datapath.sv -----
// fir decimator datapath: config registers, delay line and coefficient rams,
// shared multiply-accumulate, saturation and output register
// depends on fdec_pkg, fdec_ram and fir_decimator_assert.svh
`include "fir_decimator_assert.svh"

module fdec_datapath #(
  parameter int MAX_TAPS       = 64,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fdec_pkg::fdec_cmd_t             cmd_i,
  output fdec_pkg::fdec_status_t          status_o,
  input  logic [fdec_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fdec_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [SAMPLE_BITS-1:0]          filtered_sample_o
);
  import fdec_pkg::*;

  localparam int TAP_AW = $clog2(MAX_TAPS);
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  localparam int ACC_W  = PROD_W + TAP_AW;
  localparam int NTAPS_RST_CL = (NTAPS_RST > MAX_TAPS) ? MAX_TAPS : NTAPS_RST;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(1 <<< (SAMPLE_BITS - 1)));

  // configuration state
  logic [DECIM_W-1:0] decim_q;
  logic [CNT_W-1:0]   ntaps_q;
  logic [ADDR_W-1:0]  coef_addr_q;

  // filter state
  logic [TAP_AW-1:0]  wp_q;
  logic [PHASE_W-1:0] phase_q;
  logic [MAX_TAPS-1:0] dly_vld_q;
  logic [MAX_TAPS-1:0] coef_vld_q;

  // mac pipeline
  logic [TAP_AW-1:0]        rd_ptr_q, coef_ptr_q;
  logic                     v1_q, v2_q, dvld_q, cvld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  // output register
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_data_q;

  // ram read data
  logic [SAMPLE_BITS-1:0] dly_rdata;
  logic [COEF_W-1:0]      coef_rdata;

  // config decode
  logic dec_we, ntaps_we, addr_we, coef_we, coef_ram_we, line_clear;
  logic [DECIM_W-1:0] decim_wr, decim_cl;
  logic [NTAPS_W-1:0] ntaps_wr;
  logic [CNT_W-1:0]   ntaps_cl;

  always_comb begin
    dec_we   = 1'b0;
    ntaps_we = 1'b0;
    addr_we  = 1'b0;
    coef_we  = 1'b0;
    if (cmd_i.cfg_we) begin
      unique case (cfg_index_i)
        REG_DECIM:     dec_we   = 1'b1;
        REG_NUM_TAPS:  ntaps_we = 1'b1;
        REG_COEF_ADDR: addr_we  = 1'b1;
        REG_COEF_DATA: coef_we  = 1'b1;
        default: begin
          dec_we = 1'b0;
        end
      endcase
    end
    coef_ram_we = coef_we && (32'(coef_addr_q) < MAX_TAPS);
    line_clear  = ntaps_we || coef_we;
  end

  // clamp written values into range
  always_comb begin
    decim_wr = cfg_data_i[DECIM_W-1:0];
    ntaps_wr = cfg_data_i[NTAPS_W-1:0];
    if (decim_wr < DECIM_MIN) begin
      decim_cl = DECIM_MIN;
    end else if (decim_wr > DECIM_MAX) begin
      decim_cl = DECIM_MAX;
    end else begin
      decim_cl = decim_wr;
    end
    if (ntaps_wr == '0) begin
      ntaps_cl = CNT_W'(1);
    end else if (32'(ntaps_wr) > MAX_TAPS) begin
      ntaps_cl = CNT_W'(MAX_TAPS);
    end else begin
      ntaps_cl = CNT_W'(ntaps_wr);
    end
  end

  // pointer and phase stepping
  logic [TAP_AW-1:0]  wp_eff, wp_step, rd_ptr_nxt;
  logic [DECIM_W-1:0] phase_inc;
  logic [PHASE_W-1:0] phase_nxt;

  always_comb begin
    wp_eff    = (CNT_W'(wp_q) < ntaps_q) ? wp_q : '0;
    wp_step   = (wp_eff == '0) ? TAP_AW'(ntaps_q - CNT_W'(1)) : wp_eff - TAP_AW'(1);
    phase_inc = DECIM_W'(phase_q) + DECIM_W'(1);
    phase_nxt = (phase_inc >= decim_q) ? '0 : phase_inc[PHASE_W-1:0];
    rd_ptr_nxt = (CNT_W'(rd_ptr_q) == ntaps_q - CNT_W'(1)) ? '0 : rd_ptr_q + TAP_AW'(1);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q     <= DECIM_RST;
      ntaps_q     <= CNT_W'(NTAPS_RST_CL);
      coef_addr_q <= '0;
    end else begin
      if (dec_we) begin
        decim_q <= decim_cl;
      end
      if (ntaps_we) begin
        ntaps_q <= ntaps_cl;
      end
      if (addr_we) begin
        coef_addr_q <= cfg_data_i[ADDR_W-1:0];
      end
    end
  end

  // delay line pointer, phase and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      phase_q    <= '0;
      dly_vld_q  <= '0;
      coef_vld_q <= '0;
    end else begin
      if (line_clear) begin
        wp_q      <= '0;
        dly_vld_q <= '0;
      end else if (cmd_i.accept) begin
        wp_q              <= wp_step;
        dly_vld_q[wp_eff] <= 1'b1;
      end
      if (cmd_i.accept) begin
        phase_q <= phase_nxt;
      end
      if (coef_ram_we) begin
        coef_vld_q[TAP_AW'(coef_addr_q)] <= 1'b1;
      end
    end
  end

  // tap walk: newest-to-oldest data against coefficients from the top down
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q   <= '0;
      coef_ptr_q <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
    end else begin
      if (cmd_i.mac_start) begin
        rd_ptr_q   <= wp_eff;
        coef_ptr_q <= TAP_AW'(ntaps_q - CNT_W'(1));
      end else if (cmd_i.issue) begin
        rd_ptr_q   <= rd_ptr_nxt;
        coef_ptr_q <= coef_ptr_q - TAP_AW'(1);
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  // multiply and accumulate stages
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [COEF_W-1:0]      mul_b;

  assign mul_a = dvld_q ? signed'(dly_rdata) : '0;
  assign mul_b = cvld_q ? signed'(coef_rdata) : '0;

  always_ff @(posedge clk_i) begin
    dvld_q <= dly_vld_q[rd_ptr_q];
    cvld_q <= coef_vld_q[coef_ptr_q];
    prod_q <= mul_a * mul_b;
    if (cmd_i.mac_start) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // scale down and saturate
  logic signed [ACC_W-1:0]  acc_sh;
  logic [SAMPLE_BITS-1:0]   sat_val;

  always_comb begin
    acc_sh = acc_q >>> COEF_FRAC_BITS;
    if (acc_sh > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_BITS-1:0];
    end else if (acc_sh < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_val = acc_sh[SAMPLE_BITS-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= sat_val;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign filtered_sample_o = out_data_q;

  // rams
  fdec_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_TAPS)
  ) u_dly_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept),
    .waddr_i(wp_eff),
    .wdata_i(sample_i),
    .raddr_i(rd_ptr_q),
    .rdata_o(dly_rdata)
  );

  fdec_ram #(
    .WIDTH(COEF_W),
    .DEPTH(MAX_TAPS)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (coef_ram_we),
    .waddr_i(TAP_AW'(coef_addr_q)),
    .wdata_i(cfg_data_i[COEF_W-1:0]),
    .raddr_i(coef_ptr_q),
    .rdata_o(coef_rdata)
  );

  // status to controller
  always_comb begin
    status_o            = '0;
    status_o.phase_zero = (phase_q == '0);
    status_o.last_tap   = (coef_ptr_q == '0);
    status_o.pipe_busy  = v1_q || v2_q;
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // checks
  `FDEC_ASSERT_NOW(a_wp_range, 1'b1, CNT_W'(wp_q) < ntaps_q, "write pointer beyond tap count")
  `FDEC_ASSERT_NOW(a_start_empty, cmd_i.mac_start, !v1_q && !v2_q, "mac start with busy pipe")
  `FDEC_ASSERT_NOW(a_load_free, cmd_i.out_load, !out_valid_q || !out_stall_i, "result overwritten")

endmodule

// ----- design/fir_decimator.sv -----
// channel   | signals                                   | transfer when
// ----------+-------------------------------------------+--------------------------
// input     | in_valid_i, in_stall_o, sample_i          | in_valid_i & !in_stall_o
// output    | out_valid_o, out_stall_i, filtered_sample_o | out_valid_o & !out_stall_i
// config    | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | cfg_valid_i & cfg_ready_o
//
// a sample that yields no result is taken without a stall; a sample that yields a result
// holds the input stalled through the mac run and flush, bound by the one shared multiply-accumulate
// that walks the taps one per cycle through the delay line and coefficient rams.
// reset clears control state and the per-entry valid bits at once: no clearing pass.
// the output register lets a result wait under out_stall_i while new samples are taken;
// a finished sum holds the input stalled only while that register is still full.
// depends on fdec_pkg, fdec_ctrl and fdec_datapath
module fir_decimator #(
  parameter int MAX_TAPS       = 64,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [SAMPLE_BITS-1:0]          filtered_sample_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fdec_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fdec_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fdec_pkg::*;

  fdec_cmd_t    cmd;
  fdec_status_t status;

  // sequencer
  fdec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // filter datapath
  fdec_datapath #(
    .MAX_TAPS      (MAX_TAPS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_sample_o(filtered_sample_o)
  );

endmodule

// ----- tb/testbench.sv -----
// self-checking bench for the fir decimator: register writes, random samples and output checks
// holds its own prediction of the filter; depends on fdec_pkg and fir_decimator
module testbench;
  import fdec_pkg::*;

  localparam int SAMPLE_W       = 16;
  localparam int TAPS_MAX       = 64;
  localparam int FRAC_W         = 15;
  localparam int SETTLE_CYCLES  = TAPS_MAX + 16;
  localparam int MAX_WAIT       = 13;
  localparam int TARGET_SAMPLES = 400;

  // predicted filter state and the outputs still owed by the block
  class fir_out_tracker;
    logic signed [COEF_W-1:0]   coef_table [TAPS_MAX];
    logic signed [SAMPLE_W-1:0] delay_line [TAPS_MAX];
    int unsigned                decim, taps, coef_addr, wr_ptr, phase;
    logic signed [SAMPLE_W-1:0] expected_outputs [$];
    int unsigned                outputs_expected, outputs_checked, mismatches;

    function new();
      decim = DECIM_RST;
      taps = NTAPS_RST;
      coef_addr = 0;
      phase = 0;
      outputs_expected = 0;
      outputs_checked = 0;
      mismatches = 0;
      foreach (coef_table[i]) coef_table[i] = '0;
      clear_line();
    endfunction

    function void clear_line();
      foreach (delay_line[i]) delay_line[i] = '0;
      wr_ptr = 0;
    endfunction

    // factor and tap count both live in 1..64
    function int unsigned clamp_count(int unsigned v);
      if (v < 1) return 1;
      if (v > TAPS_MAX) return TAPS_MAX;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DECIM: decim = clamp_count(data[DECIM_W-1:0]);
        REG_NUM_TAPS: begin
          taps = clamp_count(data[NTAPS_W-1:0]);
          clear_line();
        end
        REG_COEF_ADDR: coef_addr = data[ADDR_W-1:0];
        REG_COEF_DATA: begin
          if (coef_addr < TAPS_MAX) coef_table[coef_addr] = data[COEF_W-1:0];
          clear_line();
        end
        default: ;
      endcase
    endfunction

    // one accepted sample: store it, and on phase zero work out the saturated sum
    function void note_sample(logic signed [SAMPLE_W-1:0] smp);
      longint                     acc;
      longint                     q;
      int unsigned                wp;
      int unsigned                age;
      logic signed [SAMPLE_W-1:0] y;
      wp = wr_ptr;
      if (wp >= taps) wp = 0;
      delay_line[wp] = smp;
      if (phase == 0) begin
        acc = 0;
        for (int unsigned j = 0; j < taps; j++) begin
          age = (j + taps - wp) % taps;
          acc += longint'(coef_table[taps - 1 - age]) * longint'(delay_line[j]);
        end
        q = acc >>> FRAC_W;
        if (q > longint'(2 ** (SAMPLE_W - 1) - 1)) y = {1'b0, {(SAMPLE_W-1){1'b1}}};
        else if (q < -longint'(2 ** (SAMPLE_W - 1))) y = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else y = q[SAMPLE_W-1:0];
        expected_outputs.push_back(y);
        outputs_expected++;
      end
      if (phase + 1 >= decim) phase = 0;
      else phase = phase + 1;
      wr_ptr = (wp == 0) ? taps - 1 : wp - 1;
    endfunction

    function void check_output(logic [SAMPLE_W-1:0] actual);
      logic signed [SAMPLE_W-1:0] want;
      if (expected_outputs.size() == 0) begin
        $error("filtered_sample: expected nothing, got %0d", $signed(actual));
        mismatches++;
      end else begin
        want = expected_outputs.pop_front();
        outputs_checked++;
        if (actual !== want) begin
          $error("filtered_sample: expected %0d, got %0d", want, $signed(actual));
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   sample_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [SAMPLE_W-1:0]   filtered_sample_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  fir_out_tracker tracker;
  int unsigned    samples_sent = 0;
  int unsigned    stall_left = 0;
  bit             send_quiet = 1'b0;
  bit             rx_quiet = 1'b0;

  fir_decimator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .filtered_sample_o (filtered_sample_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // output side: check each transfer, then hold off the next result for a drawn time
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) tracker.check_output(filtered_sample_o);
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        if (out_valid_o) stall_left <= stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        if (out_valid_o && !out_stall_i)
          stall_left <= rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end
    end
  end

  // one register write, valid dropped for a cycle afterwards
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one sample transfer after a drawn gap; valid stays high for a back-to-back follower
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_sample(value);
    samples_sent++;
  endtask

  task automatic wait_outputs_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // idle point for register writes: nothing owed and the accumulator finished
  task automatic quiesce();
    wait_outputs_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    int unsigned           phase_no;
    int unsigned           n_samples;
    int unsigned           n_coefs;
    int unsigned           pause_at;
    int unsigned           r;
    logic [CFG_DATA_W-1:0] val;
    logic [SAMPLE_W-1:0]   smp;
    bit                    small_coefs;
    bit                    extreme_samples;

    tracker = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_DECIM;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero coefficients, so outputs are zero
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    quiesce();

    // four full-scale taps, one output per sample: saturation both ways
    reg_write(REG_DECIM, 16'd1);
    reg_write(REG_NUM_TAPS, 16'd4);
    for (int i = 0; i < 4; i++) begin
      reg_write(REG_COEF_ADDR, CFG_DATA_W'(i));
      reg_write(REG_COEF_DATA, 16'h7FFF);
    end
    repeat (4) send_sample(16'h7FFF);
    repeat (4) send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    quiesce();

    // single tap: most negative squared, then floor rounding of small negatives
    reg_write(REG_NUM_TAPS, 16'd1);
    reg_write(REG_COEF_ADDR, 16'd0);
    reg_write(REG_COEF_DATA, 16'h8000);
    send_sample(16'h8000);
    send_sample(16'h0001);
    quiesce();
    reg_write(REG_COEF_DATA, 16'h0001);
    send_sample(16'hFFFD);
    send_sample(16'h0003);

    // random phases, each under its own settings
    phase_no = 0;
    while (samples_sent < TARGET_SAMPLES) begin
      quiesce();
      send_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet   = ($urandom_range(0, 3) == 0);

      // decimation factor, range edges first
      case (phase_no)
        0: val = 16'd0;
        1: val = 16'd64;
        2: val = 16'd127;
        3: val = 16'd1;
        default: begin
          r = $urandom_range(0, 9);
          if (r == 0) val = 16'($urandom);
          else if (r < 3) val = 16'($urandom_range(1, 64));
          else val = 16'($urandom_range(1, 12));
        end
      endcase
      reg_write(REG_DECIM, val);

      // every third phase keeps the delay line and phase across the factor change
      if (phase_no % 3 != 2) begin
        case (phase_no)
          0: val = 16'd0;
          1: val = 16'd64;
          3: val = 16'd127;
          4: val = 16'd1;
          default: begin
            r = $urandom_range(0, 9);
            if (r == 0) val = 16'($urandom);
            else if (r < 3) val = 16'($urandom_range(1, 64));
            else val = 16'($urandom_range(1, 16));
          end
        endcase
        reg_write(REG_NUM_TAPS, val);
        small_coefs = $urandom_range(0, 1);
        n_coefs = $urandom_range(1, 12);
        for (int i = 0; i < n_coefs; i++) begin
          val = 16'($urandom);
          if ($urandom_range(0, 3) != 0) val[ADDR_W-1:0] = ADDR_W'($urandom_range(0, tracker.taps - 1));
          reg_write(REG_COEF_ADDR, val);
          r = $urandom_range(0, 7);
          if (r == 0) val = 16'h7FFF;
          else if (r == 1) val = 16'h8000;
          else if (small_coefs) val = 16'(int'($urandom_range(0, 4095)) - 2048);
          else val = 16'($urandom);
          reg_write(REG_COEF_DATA, val);
        end
      end

      n_samples = $urandom_range(20, 60);
      pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, n_samples - 1) : 0;
      extreme_samples = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < n_samples; i++) begin
        // sender holds back until every owed output has been taken
        if (pause_at != 0 && i == pause_at) wait_outputs_drained();
        smp = 16'($urandom);
        if (extreme_samples && $urandom_range(0, 1) == 1)
          smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        send_sample(smp);
      end
      phase_no++;
    end

    wait_outputs_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d samples and %0d checked outputs over %0d random filter settings",
             samples_sent, tracker.outputs_checked, phase_no);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("[fir_decimator] OK");
    end else begin
      $display("[fir_decimator] ERROR");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #4000000;
    $error("run timed out with %0d outputs still owed", tracker.pending());
    $display("[fir_decimator] ERROR");
    $finish;
  end

endmodule
